// File: rtl/asq_pkg.sv
`default_nettype none

package asq_pkg;

    localparam int SAMPLE_W  = 40;
    localparam int SCALE_W   = 32;
    localparam int SPLIT_W   = 20;
    localparam int PP_W      = SPLIT_W + SCALE_W;
    localparam int MAG_W     = SAMPLE_W + SCALE_W;
    localparam int VAL_W     = MAG_W + 1;
    localparam int FRAC_W    = 24;
    localparam int Q_W       = VAL_W - FRAC_W;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 32;
    localparam int BCNT_W    = 3;
    localparam int FMT_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [VAL_W-1:0]   OFFSET_Q    = VAL_W'(128) << FRAC_W;
    localparam logic [VAL_W-1:0]   HALF_Q      = VAL_W'(1) << (FRAC_W - 1);

    typedef enum logic [FMT_W-1:0] {
        FMT_U8_OFS = 3'd0,
        FMT_S8     = 3'd1,
        FMT_S16    = 3'd2,
        FMT_S24    = 3'd3,
        FMT_S32    = 3'd4
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_SWAP   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_fmt               fmt;
        logic [SCALE_W-1:0] k_mag;
        logic               k_neg;
        logic               swap;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             last;
    } t_mag_item;

    typedef struct packed {
        logic [WORD_W-1:0] q;
        logic              neg;
        logic              clip_hi;
        logic              clip_lo;
        logic              last;
    } t_rnd_item;

    // largest positive value of the format
    function automatic logic [WORD_W-1:0] fmt_max(input t_fmt fmt);
        logic [WORD_W-1:0] res;
        case (fmt)
            FMT_U8_OFS: res = WORD_W'(255);
            FMT_S8:     res = WORD_W'(127);
            FMT_S16:    res = WORD_W'(32767);
            FMT_S24:    res = WORD_W'(8388607);
            default:    res = WORD_W'(2147483647);
        endcase
        return res;
    endfunction

    // magnitude of the most negative value of the format
    function automatic logic [WORD_W-1:0] fmt_min_mag(input t_fmt fmt);
        logic [WORD_W-1:0] res;
        case (fmt)
            FMT_U8_OFS: res = '0;
            FMT_S8:     res = WORD_W'(128);
            FMT_S16:    res = WORD_W'(32768);
            FMT_S24:    res = WORD_W'(8388608);
            default:    res = WORD_W'(1) << (WORD_W - 1);
        endcase
        return res;
    endfunction

    function automatic logic [BCNT_W-1:0] fmt_bytes(input t_fmt fmt);
        logic [BCNT_W-1:0] res;
        case (fmt)
            FMT_U8_OFS: res = BCNT_W'(1);
            FMT_S8:     res = BCNT_W'(1);
            FMT_S16:    res = BCNT_W'(2);
            FMT_S24:    res = BCNT_W'(3);
            default:    res = BCNT_W'(4);
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/asq_cfg_regs.sv
`default_nettype none

module asq_cfg_regs
    import asq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_fmt n_fmt;
    logic [SCALE_W-1:0] n_k_mag;

    // unused format codes behave as signed 32-bit
    always_comb begin
        if (i_cfg_data[FMT_W-1:0] > FMT_S32) begin
            n_fmt = FMT_S32;
        end else begin
            n_fmt = t_fmt'(i_cfg_data[FMT_W-1:0]);
        end
        n_k_mag = i_cfg_data[SCALE_W-1] ? (SCALE_W'(0) - i_cfg_data[SCALE_W-1:0])
                                        : i_cfg_data[SCALE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt   <= FMT_S16;
            r_cfg.k_mag <= SCALE_RESET;
            r_cfg.k_neg <= 1'b0;
            r_cfg.swap  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORMAT: r_cfg.fmt <= n_fmt;
                CFG_SCALE: begin
                    r_cfg.k_mag <= n_k_mag;
                    r_cfg.k_neg <= i_cfg_data[SCALE_W-1];
                end
                CFG_SWAP:   r_cfg.swap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

`default_nettype wire

// File: rtl/asq_scale.sv
`default_nettype none

module asq_scale
    import asq_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last,
    input  wire logic [SCALE_W-1:0]         i_k_mag,
    input  wire logic                       i_k_neg,
    output logic                            o_valid,
    output t_mag_item                       o_item
);

    logic                r0_valid, r1_valid, r2_valid;
    logic [SAMPLE_W-1:0] r0_mag;
    logic                r0_neg, r0_last;
    logic [PP_W-1:0]     r1_pp_lo, r1_pp_hi;
    logic                r1_neg, r1_last;
    t_mag_item           r2_item;
    logic [SAMPLE_W-1:0] n0_mag;

    assign n0_mag = i_sample[SAMPLE_W-1] ? $unsigned(-i_sample) : $unsigned(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // sign-magnitude input
            r0_mag  <= n0_mag;
            r0_neg  <= i_sample[SAMPLE_W-1] ^ i_k_neg;
            r0_last <= i_last;
            // two partial products on the halves of the magnitude
            r1_pp_lo <= r0_mag[SPLIT_W-1:0] * i_k_mag;
            r1_pp_hi <= r0_mag[SAMPLE_W-1:SPLIT_W] * i_k_mag;
            r1_neg   <= r0_neg;
            r1_last  <= r0_last;
            r2_item.mag  <= {r1_pp_hi, SPLIT_W'(0)} + MAG_W'(r1_pp_lo);
            r2_item.neg  <= r1_neg;
            r2_item.last <= r1_last;
        end
    end

    assign o_valid = r2_valid;
    assign o_item  = r2_item;

endmodule

`default_nettype wire

// File: rtl/asq_round.sv
`default_nettype none

module asq_round
    import asq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_valid,
    input  wire t_mag_item i_item,
    input  wire t_fmt      i_fmt,
    output logic           o_valid,
    output t_rnd_item      o_item
);

    logic             r3_valid, r4_valid;
    logic [VAL_W-1:0] r3_v;
    logic             r3_last;
    t_rnd_item        r4_item;

    logic [VAL_W-1:0] n3_off, n3_v, n4_t;
    logic [Q_W-1:0]   n4_q;
    logic             n4_neg;

    always_comb begin
        n3_off = (i_fmt == FMT_U8_OFS) ? OFFSET_Q : '0;
        n3_v   = i_item.neg ? (n3_off - VAL_W'(i_item.mag)) : (n3_off + VAL_W'(i_item.mag));
        // round half away from zero on the magnitude
        n4_neg = r3_v[VAL_W-1];
        n4_t   = n4_neg ? (HALF_Q - r3_v) : (r3_v + HALF_Q);
        n4_q   = n4_t[VAL_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_v            <= n3_v;
            r3_last         <= i_item.last;
            r4_item.q       <= n4_q[WORD_W-1:0];
            r4_item.neg     <= n4_neg;
            r4_item.clip_hi <= !n4_neg && (n4_q > Q_W'(fmt_max(i_fmt)));
            r4_item.clip_lo <= n4_neg && (n4_q > Q_W'(fmt_min_mag(i_fmt)));
            r4_item.last    <= r3_last;
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;

endmodule

`default_nettype wire

// File: rtl/asq_pack.sv
`default_nettype none

module asq_pack
    import asq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_rnd_item   i_item,
    input  wire t_fmt        i_fmt,
    input  wire logic        i_swap,
    output logic             o_valid,
    output logic [WORD_W-1:0] o_packed_bytes,
    output logic [BCNT_W-1:0] o_byte_count,
    output logic             o_clipped,
    output logic [CNT_W-1:0] o_overload_total,
    output logic             o_last_out
);

    logic              r_valid;
    logic [WORD_W-1:0] r_packed;
    logic [BCNT_W-1:0] r_bcnt;
    logic              r_clipped;
    logic              r_last;
    logic [CNT_W-1:0]  r_cnt;

    logic [WORD_W-1:0] n_word, n_packed;
    logic              n_clip;

    always_comb begin
        n_clip = i_item.clip_hi || i_item.clip_lo;
        priority if (i_item.clip_hi) begin
            n_word = fmt_max(i_fmt);
        end else if (i_item.clip_lo) begin
            n_word = WORD_W'(0) - fmt_min_mag(i_fmt);
        end else if (i_item.neg) begin
            n_word = WORD_W'(0) - i_item.q;
        end else begin
            n_word = i_item.q;
        end

        case (i_fmt)
            FMT_U8_OFS, FMT_S8: n_packed = {24'd0, n_word[7:0]};
            FMT_S16: n_packed = i_swap ? {16'd0, n_word[7:0], n_word[15:8]}
                                       : {16'd0, n_word[15:0]};
            FMT_S24: n_packed = i_swap ? {8'd0, n_word[7:0], n_word[15:8], n_word[23:16]}
                                       : {8'd0, n_word[23:0]};
            default: n_packed = i_swap ? {n_word[7:0], n_word[15:8], n_word[23:16],
                                          n_word[31:24]}
                                       : n_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid && n_clip && (r_cnt != '1)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_packed  <= n_packed;
            r_bcnt    <= fmt_bytes(i_fmt);
            r_clipped <= n_clip;
            r_last    <= i_item.last;
        end
    end

    assign o_valid          = r_valid;
    assign o_packed_bytes   = r_packed;
    assign o_byte_count     = r_bcnt;
    assign o_clipped        = r_clipped;
    assign o_overload_total = r_cnt;
    assign o_last_out       = r_last;

endmodule

`default_nettype wire

// File: rtl/audio_sample_quantizer.sv
// Channel  Direction  Handshake                    Payload
// in       input      i_valid / o_ready            i_sample, i_last
// out      output     o_valid / i_ready            o_packed_bytes, o_byte_count, o_clipped,
//                                                  o_overload_total, o_last_out
// cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One transaction per cycle in and out while the output is not stalled.
// Six register stages: sample magnitude, split multiply, product sum, offset,
// round and clip, pack into the output register.
// The whole pipeline advances together: it stalls only while the output holds
// a result that is not taken. o_cfg_ready is always high.
// Synchronous reset clears the valid bits, the overload counter and the configuration
// registers.
`default_nettype none

module audio_sample_quantizer
    import asq_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [WORD_W-1:0]               o_packed_bytes,
    output logic [BCNT_W-1:0]               o_byte_count,
    output logic                            o_clipped,
    output logic [CNT_W-1:0]                o_overload_total,
    output logic                            o_last_out,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [WORD_W-1:0]          i_cfg_data
);

    t_cfg      cfg;
    logic      en;
    logic      mag_valid, rnd_valid;
    t_mag_item mag_item;
    t_rnd_item rnd_item;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    asq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    asq_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_k_mag  (cfg.k_mag),
        .i_k_neg  (cfg.k_neg),
        .o_valid  (mag_valid),
        .o_item   (mag_item)
    );

    asq_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mag_valid),
        .i_item  (mag_item),
        .i_fmt   (cfg.fmt),
        .o_valid (rnd_valid),
        .o_item  (rnd_item)
    );

    asq_pack u_pack (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (rnd_valid),
        .i_item           (rnd_item),
        .i_fmt            (cfg.fmt),
        .i_swap           (cfg.swap),
        .o_valid          (o_valid),
        .o_packed_bytes   (o_packed_bytes),
        .o_byte_count     (o_byte_count),
        .o_clipped        (o_clipped),
        .o_overload_total (o_overload_total),
        .o_last_out       (o_last_out)
    );

endmodule

`default_nettype wire

// File: tb/quantizer_monitor.sv
`default_nettype none

module quantizer_monitor
    import asq_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       o_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic [WORD_W-1:0]          o_packed_bytes,
    input  wire logic [BCNT_W-1:0]          o_byte_count,
    input  wire logic                       o_clipped,
    input  wire logic [CNT_W-1:0]           o_overload_total,
    input  wire logic                       o_last_out,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [WORD_W-1:0]          i_cfg_data,
    output int                              mismatch_count,
    output int                              pending_count,
    output int                              result_count,
    output int                              clip_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W = 80;
    localparam logic signed [ACC_W-1:0] U8_BIAS   = 80'sd128 <<< FRAC_W;
    localparam logic signed [ACC_W-1:0] HALF_STEP = 80'sd1 <<< (FRAC_W - 1);

    typedef struct packed {
        logic [WORD_W-1:0] packed_bytes;
        logic [BCNT_W-1:0] byte_count;
        logic              clipped;
        logic [CNT_W-1:0]  overload_total;
        logic              last_out;
    } t_quant_result;

    t_quant_result             expected_q[$];
    logic [FMT_W-1:0]          fmt_reg;
    logic signed [SCALE_W-1:0] gain_reg;
    logic                      swap_reg;
    logic [CNT_W-1:0]          overload_cnt;
    int                        errors;
    int                        results;
    int                        clips;

    // scale, bias, round half away from zero, clip, then pack bytes
    function automatic t_quant_result quantize_sample(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       lst,
        input logic [FMT_W-1:0]           fmt_code,
        input logic signed [SCALE_W-1:0]  gain,
        input logic                       swap,
        input logic [CNT_W-1:0]           count_in
    );
        t_fmt                     fmt;
        logic signed [ACC_W-1:0]  v;
        logic signed [ACC_W-1:0]  m;
        logic signed [ACC_W-1:0]  q;
        logic signed [ACC_W-1:0]  lo_lim;
        logic signed [ACC_W-1:0]  hi_lim;
        logic [WORD_W-1:0]        word;
        int                       nb;
        int                       src;
        t_quant_result            res;
        fmt = (fmt_code > FMT_S32) ? FMT_S32 : t_fmt'(fmt_code);
        v = smp;
        m = gain;
        v = v * m;
        if (fmt == FMT_U8_OFS) begin
            v = v + U8_BIAS;
        end
        m = (v < 0) ? -v : v;
        q = (m + HALF_STEP) >>> FRAC_W;
        if (v < 0) begin
            q = -q;
        end
        case (fmt)
            FMT_U8_OFS: begin
                lo_lim = 0;
                hi_lim = 255;
                nb = 1;
            end
            FMT_S8: begin
                lo_lim = -128;
                hi_lim = 127;
                nb = 1;
            end
            FMT_S16: begin
                lo_lim = -32768;
                hi_lim = 32767;
                nb = 2;
            end
            FMT_S24: begin
                lo_lim = -8388608;
                hi_lim = 8388607;
                nb = 3;
            end
            default: begin
                lo_lim = -80'sd2147483648;
                hi_lim = 80'sd2147483647;
                nb = 4;
            end
        endcase
        res.clipped = 1'b0;
        if (q > hi_lim) begin
            q = hi_lim;
            res.clipped = 1'b1;
        end else if (q < lo_lim) begin
            q = lo_lim;
            res.clipped = 1'b1;
        end
        word = q[WORD_W-1:0];
        res.packed_bytes = '0;
        for (int i = 0; i < nb; i++) begin
            src = swap ? (nb - 1 - i) : i;
            res.packed_bytes[8*i +: 8] = word[8*src +: 8];
        end
        res.byte_count = BCNT_W'(nb);
        res.overload_total = (res.clipped && count_in != '1) ? count_in + 1'b1 : count_in;
        res.last_out = lst;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_quant_result want;
        t_quant_result got;
        if (!i_rst_n) begin
            expected_q.delete();
            fmt_reg = FMT_S16;
            gain_reg = SCALE_RESET;
            swap_reg = 1'b0;
            overload_cnt = '0;
            errors = 0;
            results = 0;
            clips = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FORMAT: fmt_reg = i_cfg_data[FMT_W-1:0];
                    CFG_SCALE:  gain_reg = i_cfg_data;
                    CFG_SWAP:   swap_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                want = quantize_sample(i_sample, i_last, fmt_reg, gain_reg, swap_reg,
                                       overload_cnt);
                overload_cnt = want.overload_total;
                expected_q.push_back(want);
            end
            if (o_valid && i_ready) begin
                got = '{o_packed_bytes, o_byte_count, o_clipped, o_overload_total, o_last_out};
                results++;
                if (o_clipped === 1'b1) begin
                    clips++;
                end
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: result with nothing expected: bytes=%h", $realtime,
                                 o_packed_bytes);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.packed_bytes !== want.packed_bytes
                            || got.byte_count !== want.byte_count
                            || got.clipped !== want.clipped
                            || got.overload_total !== want.overload_total
                            || got.last_out !== want.last_out) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, results);
                            $display("  exp bytes=%h cnt=%0d clip=%b total=%0d last=%b",
                                     want.packed_bytes, want.byte_count, want.clipped,
                                     want.overload_total, want.last_out);
                            $display("  got bytes=%h cnt=%0d clip=%b total=%0d last=%b",
                                     got.packed_bytes, got.byte_count, got.clipped,
                                     got.overload_total, got.last_out);
                        end
                    end
                end
            end
        end
        mismatch_count <= errors;
        pending_count <= expected_q.size();
        result_count <= results;
        clip_count <= clips;
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench
    import asq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 127;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [WORD_W-1:0]          o_packed_bytes;
    logic [BCNT_W-1:0]          o_byte_count;
    logic                       o_clipped;
    logic [CNT_W-1:0]           o_overload_total;
    logic                       o_last_out;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [WORD_W-1:0]          i_cfg_data = '0;

    int mismatch_count;
    int pending_count;
    int result_count;
    int clip_count;

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int n_settings = 0;
    int idle_cycles = 0;

    audio_sample_quantizer i_dut (.*);

    quantizer_monitor monitor (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // output side backpressure
    initial begin : sink
        int stall;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= smp;
        i_last <= lst;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits are don't-care for format and swap, so randomize them
    task automatic configure(input logic [FMT_W-1:0] fmt_code, input logic [WORD_W-1:0] gain,
                             input logic swap);
        drain();
        write_reg(CFG_FORMAT, ($urandom & ~WORD_W'(7)) | WORD_W'(fmt_code));
        write_reg(CFG_SCALE, gain);
        write_reg(CFG_SWAP, ($urandom & ~WORD_W'(1)) | WORD_W'(swap));
        n_settings++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        logic signed [SAMPLE_W-1:0] raw;
        raw = {8'($urandom), $urandom};
        case ($urandom_range(0, 3))
            0: ;
            1, 2: raw = raw >>> (SAMPLE_W - $urandom_range(2, SAMPLE_W));
            default: begin
                raw = raw >>> (SAMPLE_W - $urandom_range(9, 34));
                raw[7:0] = 8'h80;
            end
        endcase
        return raw;
    endfunction

    function automatic logic [WORD_W-1:0] draw_gain();
        logic [WORD_W-1:0] g;
        case ($urandom_range(0, 7))
            0: g = 32'h8000_0000;
            1: g = 32'h7FFF_FFFF;
            2: g = '0;
            3: g = 32'h0001_0000;
            4: g = 32'hFFFF_0000;
            default: begin
                g = $urandom;
                g = $signed(g) >>> $urandom_range(8, 31);
            end
        endcase
        return g;
    endfunction

    initial begin : stimulus
        logic [FMT_W-1:0] fmt_code;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: signed 16-bit, unity gain; rounding ties and clip edges
        push_sample(40'sd0, 1'b0);
        push_sample(40'sh180, 1'b1);
        push_sample(-40'sh180, 1'b0);
        push_sample(40'sh17F, 1'b0);
        push_sample(-40'sh17F, 1'b1);
        push_sample(40'sh7F_FFFF_FFFF, 1'b0);
        push_sample(40'sh80_0000_0000, 1'b1);
        push_sample(40'sh7F_FF00, 1'b0);
        push_sample(40'sh7F_FF80, 1'b0);
        push_sample(-40'sh80_0000, 1'b1);
        push_sample(-40'sh80_0080, 1'b0);

        // offset binary: bias pulls small negatives back into range
        configure(FMT_U8_OFS, 32'h0001_0000, 1'b1);
        push_sample(-40'sh8000, 1'b0);
        push_sample(-40'sh8080, 1'b1);
        push_sample(40'sh7F80, 1'b0);
        push_sample(40'sh7F00, 1'b1);

        configure(FMT_S8, 32'h8000_0000, 1'b0);
        push_sample(40'sh80_0000_0000, 1'b0);
        push_sample(40'sd1, 1'b1);
        push_sample(40'sd2, 1'b0);

        // unused format code behaves as 32-bit
        configure(3'd7, 32'h7FFF_FFFF, 1'b1);
        push_sample(40'sh100, 1'b1);
        push_sample(40'sh7F_FFFF_FFFF, 1'b0);

        configure(FMT_S24, 32'h0001_0000, 1'b1);
        write_reg(CFG_UNMAPPED, $urandom);
        push_sample(40'sh1234_5600, 1'b0);
        push_sample(-40'sh1234_5600, 1'b1);

        configure(FMT_S32, 32'h0000_0000, 1'b0);
        push_sample(40'sh7F_FFFF_FFFF, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            fmt_code = (p < 8) ? FMT_W'(p) : FMT_W'($urandom_range(0, 7));
            configure(fmt_code, (p == 0) ? SCALE_RESET : draw_gain(), 1'($urandom));
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) push_sample(draw_sample(), 1'($urandom));
        end

        drain();
        $display("Checked %0d samples across %0d register settings, %0d of them clipped.",
                 result_count, n_settings, clip_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatch_count,
                     pending_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
